// ----- src/bil_pkg.sv -----
package bil_pkg;

	localparam int NUM_W       = 16;
	localparam int PRICE_W     = 24;
	localparam int TOTAL_W     = 29;
	localparam int CAP_W       = 6;
	localparam int MAX_ENTRIES_DEF = 32;
	localparam logic [CAP_W-1:0] CAP_RESET = 6'd20;

	// command codes
	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_LIST   = 2'd2;

	// status codes
	localparam logic [1:0] STAT_DONE      = 2'd0;
	localparam logic [1:0] STAT_FULL      = 2'd1;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
	localparam logic [1:0] STAT_ENTRY     = 2'd3;

	typedef struct packed {
		logic [1:0]         command;
		logic [NUM_W-1:0]   item_number;
		logic [PRICE_W-1:0] item_price;
	} bil_req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [NUM_W-1:0]   out_number;
		logic [PRICE_W-1:0] out_price;
		logic [TOTAL_W-1:0] total_cents;
		logic               last_flag;
	} bil_rsp_t;

	typedef struct packed {
		logic [NUM_W-1:0]   number;
		logic [PRICE_W-1:0] price;
	} bil_entry_t;

	typedef struct packed {
		logic we;
		logic re;
	} bil_mem_ctl_t;

endpackage

// ----- src/bil_store.sv -----
module bil_store #(
	parameter int DEPTH = bil_pkg::MAX_ENTRIES_DEF
) (
	input  logic                       clk,
	input  bil_pkg::bil_mem_ctl_t      ctl,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  bil_pkg::bil_entry_t        wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output bil_pkg::bil_entry_t        rdata
);

	bil_pkg::bil_entry_t mem [DEPTH];

	// write one entry
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr] <= wdata;
		end
	end

	// read one entry, hold the data until the next read
	always_ff @(posedge clk) begin
		if (ctl.re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/bounded_item_list_with_total.sv -----
// Bounded item list with running total.
// Request channel (req_valid/req_ready/req) takes one command word: add an
// entry, delete the first entry with a number, or list all entries. Response
// channel (rsp_valid/rsp_ready/rsp) returns one word for add and delete, and
// one word per stored entry plus a final total word for list.
// cfg_we/cfg_wdata write the capacity register; the user is to do so only at
// an idle clock edge; the block itself does not enforce this.
// Timing: requests are taken only while the sequencer is idle, from the cycle
// after the final word of the previous request is registered. An add passes
// through the dispatch and response states before its word is registered;
// delete searches and shifts over the stored entries, one entry a cycle
// through the read and write ports of the entry memory; list gives one entry
// word per cycle while the receiver does not stall, then the total word, as
// set by the registered read of the memory pipelined against the output.
// A response word sits in an output register; while the receiver stalls,
// the list walk holds its read data and the sequencer waits, nothing is lost.
// Reset clears the entry count and loads capacity 20; memory contents are
// not cleared since an entry is only read after it was written.
module bounded_item_list_with_total #(
	parameter int MAX_ENTRIES = bil_pkg::MAX_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  bil_pkg::bil_req_t           req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output bil_pkg::bil_rsp_t           rsp,
	input  logic                        cfg_we,
	input  logic [bil_pkg::CAP_W-1:0]   cfg_wdata
);

	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = bil_pkg::CAP_W + CNT_W;
	localparam int TOTAL_W = bil_pkg::TOTAL_W;

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_DISPATCH = 6'b000010,
		S_SEARCH   = 6'b000100,
		S_SHIFT    = 6'b001000,
		S_LIST     = 6'b010000,
		S_RESP     = 6'b100000
	} state_t;

	state_t                       state_q, state_d;
	logic [bil_pkg::CAP_W-1:0]    cap_q;
	logic [CNT_W-1:0]             count_q, count_d;
	logic [CNT_W-1:0]             idx_q, idx_d;
	logic [TOTAL_W-1:0]           total_q, total_d;
	logic [1:0]                   status_q, status_d;
	bil_pkg::bil_req_t            cmd_q;
	bil_pkg::bil_rsp_t            rsp_q, rsp_d;
	logic                         rsp_valid_q;
	logic                         emit;
	logic                         slot_free;
	logic                         full;
	logic [CMP_W-1:0]             eff_cap;
	logic [CNT_W:0]               nxt1, nxt2, cnt_x;
	logic [TOTAL_W:0]             sum;

	bil_pkg::bil_mem_ctl_t        mem_ctl;
	logic [IDX_W-1:0]             waddr, raddr;
	bil_pkg::bil_entry_t          wdata, rdata;

	bil_store #(
		.DEPTH(MAX_ENTRIES)
	) u_store (
		.clk  (clk),
		.ctl  (mem_ctl),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign slot_free = !rsp_valid_q || rsp_ready;

	// clamp capacity: zero means default, limit to memory depth
	always_comb begin
		eff_cap = (cap_q == '0) ? CMP_W'(bil_pkg::CAP_RESET) : CMP_W'(cap_q);
		if (eff_cap > CMP_W'(MAX_ENTRIES)) begin
			eff_cap = CMP_W'(MAX_ENTRIES);
		end
	end
	assign full = CMP_W'(count_q) >= eff_cap;

	assign nxt1  = {1'b0, idx_q} + (CNT_W+1)'(1);
	assign nxt2  = {1'b0, idx_q} + (CNT_W+1)'(2);
	assign cnt_x = {1'b0, count_q};
	assign sum   = {1'b0, total_q} + (TOTAL_W+1)'(rdata.price);

	// sequence the commands over the entry memory
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		idx_d    = idx_q;
		total_d  = total_q;
		status_d = status_q;
		mem_ctl  = '0;
		waddr    = count_q[IDX_W-1:0];
		wdata    = {cmd_q.item_number, cmd_q.item_price};
		raddr    = '0;
		emit     = 1'b0;
		rsp_d    = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (cmd_q.command)
					bil_pkg::CMD_ADD: begin
						if (full) begin
							status_d = bil_pkg::STAT_FULL;
						end else begin
							mem_ctl.we = 1'b1;
							count_d    = count_q + CNT_W'(1);
							status_d   = bil_pkg::STAT_DONE;
						end
						state_d = S_RESP;
					end
					bil_pkg::CMD_DELETE: begin
						if (count_q == '0) begin
							status_d = bil_pkg::STAT_NOT_FOUND;
							state_d  = S_RESP;
						end else begin
							mem_ctl.re = 1'b1;
							idx_d      = '0;
							state_d    = S_SEARCH;
						end
					end
					bil_pkg::CMD_LIST: begin
						mem_ctl.re = (count_q != '0);
						idx_d      = '0;
						total_d    = '0;
						state_d    = S_LIST;
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_SEARCH: begin
				if (rdata.number == cmd_q.item_number) begin
					if (nxt1 < cnt_x) begin
						mem_ctl.re = 1'b1;
						raddr      = nxt1[IDX_W-1:0];
						state_d    = S_SHIFT;
					end else begin
						count_d  = count_q - CNT_W'(1);
						status_d = bil_pkg::STAT_DONE;
						state_d  = S_RESP;
					end
				end else if (nxt1 < cnt_x) begin
					mem_ctl.re = 1'b1;
					raddr      = nxt1[IDX_W-1:0];
					idx_d      = nxt1[CNT_W-1:0];
				end else begin
					status_d = bil_pkg::STAT_NOT_FOUND;
					state_d  = S_RESP;
				end
			end
			S_SHIFT: begin
				// move the later entry down one place
				mem_ctl.we = 1'b1;
				waddr      = idx_q[IDX_W-1:0];
				wdata      = rdata;
				if (nxt2 < cnt_x) begin
					mem_ctl.re = 1'b1;
					raddr      = nxt2[IDX_W-1:0];
					idx_d      = nxt1[CNT_W-1:0];
				end else begin
					count_d  = count_q - CNT_W'(1);
					status_d = bil_pkg::STAT_DONE;
					state_d  = S_RESP;
				end
			end
			S_LIST: begin
				if (slot_free) begin
					emit = 1'b1;
					if (idx_q == count_q) begin
						rsp_d.status      = bil_pkg::STAT_DONE;
						rsp_d.total_cents = total_q;
						rsp_d.last_flag   = 1'b1;
						state_d           = S_IDLE;
					end else begin
						rsp_d.status     = bil_pkg::STAT_ENTRY;
						rsp_d.out_number = rdata.number;
						rsp_d.out_price  = rdata.price;
						total_d          = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
						idx_d            = nxt1[CNT_W-1:0];
						if (nxt1 < cnt_x) begin
							mem_ctl.re = 1'b1;
							raddr      = nxt1[IDX_W-1:0];
						end
					end
				end
			end
			S_RESP: begin
				if (slot_free) begin
					emit            = 1'b1;
					rsp_d.status    = status_q;
					rsp_d.last_flag = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cap_q       <= bil_pkg::CAP_RESET;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		total_q  <= total_d;
		status_q <= status_d;
		if (req_valid && req_ready) begin
			cmd_q <= req;
		end
		if (emit) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

	localparam int MAX_ENTRIES = bil_pkg::MAX_ENTRIES_DEF;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam longint TOTAL_MAX = (longint'(1) << bil_pkg::TOTAL_W) - 1;
	localparam int SETTLE_CYCLES = MAX_ENTRIES + 8;
	localparam int CYCLE_LIMIT = 1000000;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	bil_pkg::bil_req_t req;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	bil_pkg::bil_rsp_t rsp;
	logic cfg_we;
	logic [bil_pkg::CAP_W-1:0] cfg_wdata;

	// predicted list contents and capacity register
	bil_pkg::bil_entry_t held_entries [MAX_ENTRIES];
	int held_count;
	logic [bil_pkg::CAP_W-1:0] cap_setting;

	// response words owed by the block, oldest first
	bil_pkg::bil_rsp_t list_words_due [$];

	int burst_left;
	int mismatch_count = 0;
	int words_sent;
	int words_checked = 0;
	int cycle_count = 0;
	int ready_span = 0;
	int ready_mode = 0;

	bounded_item_list_with_total #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	// ---------------------------------------------------------------
	// Prediction
	// ---------------------------------------------------------------

	function automatic bil_pkg::bil_rsp_t make_word(input logic [1:0] st,
			input logic [bil_pkg::NUM_W-1:0] num, input logic [bil_pkg::PRICE_W-1:0] price,
			input logic [bil_pkg::TOTAL_W-1:0] total, input logic last);
		bil_pkg::bil_rsp_t w;
		w.status = st;
		w.out_number = num;
		w.out_price = price;
		w.total_cents = total;
		w.last_flag = last;
		return w;
	endfunction

	// zero means the reset capacity, and the array size caps the rest
	function automatic int eff_capacity();
		int c;
		c = (cap_setting == '0) ? int'(bil_pkg::CAP_RESET) : int'(cap_setting);
		if (c > MAX_ENTRIES)
			c = MAX_ENTRIES;
		return c;
	endfunction

	// update the held list and queue the words one command produces
	function automatic void apply_list_command(input bil_pkg::bil_req_t w);
		int pos;
		int j;
		longint total;
		case (w.command)
			bil_pkg::CMD_ADD: begin
				if (held_count >= eff_capacity()) begin
					list_words_due.push_back(make_word(bil_pkg::STAT_FULL, '0, '0, '0, 1'b1));
				end else begin
					held_entries[held_count].number = w.item_number;
					held_entries[held_count].price = w.item_price;
					held_count++;
					list_words_due.push_back(make_word(bil_pkg::STAT_DONE, '0, '0, '0, 1'b1));
				end
			end
			bil_pkg::CMD_DELETE: begin
				pos = 0;
				while (pos < held_count && held_entries[pos].number != w.item_number)
					pos++;
				if (pos >= held_count) begin
					list_words_due.push_back(make_word(bil_pkg::STAT_NOT_FOUND, '0, '0, '0,
						1'b1));
				end else begin
					// close the gap left by the removed entry
					for (j = pos; j + 1 < held_count; j++)
						held_entries[j] = held_entries[j + 1];
					held_count--;
					list_words_due.push_back(make_word(bil_pkg::STAT_DONE, '0, '0, '0, 1'b1));
				end
			end
			bil_pkg::CMD_LIST: begin
				total = 0;
				for (j = 0; j < held_count; j++) begin
					list_words_due.push_back(make_word(bil_pkg::STAT_ENTRY,
						held_entries[j].number, held_entries[j].price, '0, 1'b0));
					total += held_entries[j].price;
					if (total > TOTAL_MAX)
						total = TOTAL_MAX;
				end
				list_words_due.push_back(make_word(bil_pkg::STAT_DONE, '0, '0,
					total[bil_pkg::TOTAL_W-1:0], 1'b1));
			end
			default: begin
				// unused command: no state change, no word
			end
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Request side
	// ---------------------------------------------------------------

	// send one request word, idling between bursts
	task automatic send_word(input bil_pkg::bil_req_t w);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) :
				$urandom_range(1, 10);
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req <= w;
		do @(posedge clk); while (!req_ready);
		apply_list_command(w);
		words_sent++;
		burst_left--;
	endtask

	task automatic send_cmd(input logic [1:0] cmd, input logic [bil_pkg::NUM_W-1:0] num,
			input logic [bil_pkg::PRICE_W-1:0] price);
		bil_pkg::bil_req_t w;
		w.command = cmd;
		w.item_number = num;
		w.item_price = price;
		send_word(w);
	endtask

	// drop valid and hold until every owed word has come back
	task automatic wait_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (list_words_due.size() != 0)
			@(posedge clk);
	endtask

	// write capacity only with the block idle; an ignored command may still be in flight
	task automatic write_capacity(input logic [bil_pkg::CAP_W-1:0] value);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cap_setting = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// ---------------------------------------------------------------
	// Response side
	// ---------------------------------------------------------------

	// stall the receiver in spans: always ready, random, or a fixed duty
	always @(negedge clk) begin
		if (ready_span == 0) begin
			ready_mode <= $urandom_range(0, 2);
			ready_span <= $urandom_range(16, 96);
		end else begin
			ready_span <= ready_span - 1;
		end
		case (ready_mode)
			0: rsp_ready <= 1'b1;
			1: rsp_ready <= ($urandom_range(0, 3) != 0);
			default: rsp_ready <= (ready_span[2:0] > 3'd2);
		endcase
	end

	function automatic string word_text(input bil_pkg::bil_rsp_t w);
		return $sformatf("status=%0d number=%h price=%h total=%0d last=%b",
			w.status, w.out_number, w.out_price, w.total_cents, w.last_flag);
	endfunction

	// compare each accepted word with the oldest owed one
	always @(posedge clk) begin
		bil_pkg::bil_rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (list_words_due.size() == 0) begin
				$display("%0t: no word expected, actual %s", $time, word_text(rsp));
				mismatch_count++;
			end else begin
				want = list_words_due.pop_front();
				words_checked++;
				if (rsp.status !== want.status || rsp.out_number !== want.out_number ||
						rsp.out_price !== want.out_price ||
						rsp.total_cents !== want.total_cents ||
						rsp.last_flag !== want.last_flag) begin
					$display("%0t: expected %s", $time, word_text(want));
					$display("%0t:   actual %s", $time, word_text(rsp));
					mismatch_count++;
				end
			end
		end
	end

	// bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still owed", cycle_count,
				list_words_due.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// empty list: list, delete and the unused command
	task automatic test_empty_list();
		send_cmd(bil_pkg::CMD_LIST, 16'h0000, 24'h000000);
		send_cmd(bil_pkg::CMD_DELETE, 16'hFFFF, 24'hFFFFFF);
		send_cmd(CMD_UNUSED, 16'hFFFF, 24'hFFFFFF);
		send_cmd(bil_pkg::CMD_LIST, 16'hFFFF, 24'hFFFFFF);
		wait_drained();
	endtask

	// field extremes, duplicate numbers, not found
	task automatic test_edge_values();
		send_cmd(bil_pkg::CMD_ADD, 16'h0000, 24'h000000);
		send_cmd(bil_pkg::CMD_ADD, 16'hFFFF, 24'hFFFFFF);
		send_cmd(bil_pkg::CMD_ADD, 16'h1234, 24'h000005);
		send_cmd(bil_pkg::CMD_ADD, 16'h1234, 24'h000007);
		send_cmd(bil_pkg::CMD_LIST, 16'h0000, 24'h000000);
		send_cmd(bil_pkg::CMD_DELETE, 16'h1234, 24'hABCDEF);
		send_cmd(bil_pkg::CMD_DELETE, 16'h9999, 24'h000000);
		send_cmd(bil_pkg::CMD_LIST, 16'h0000, 24'h000000);
		send_cmd(bil_pkg::CMD_DELETE, 16'hFFFF, 24'h000000);
		send_cmd(bil_pkg::CMD_DELETE, 16'h0000, 24'h000000);
		send_cmd(bil_pkg::CMD_LIST, 16'h0000, 24'h000000);
		wait_drained();
	endtask

	// small capacity, and capacity lowered below the count
	task automatic test_capacity_limits();
		write_capacity(6'd2);
		send_cmd(bil_pkg::CMD_ADD, 16'hABCD, 24'h000100);
		send_cmd(bil_pkg::CMD_ADD, 16'h5555, 24'h000001);
		write_capacity(6'd1);
		send_cmd(bil_pkg::CMD_ADD, 16'h5555, 24'h000001);
		send_cmd(bil_pkg::CMD_DELETE, 16'hABCD, 24'h000000);
		send_cmd(bil_pkg::CMD_DELETE, 16'h1234, 24'h000000);
		send_cmd(bil_pkg::CMD_ADD, 16'h0007, 24'h000007);
		send_cmd(bil_pkg::CMD_ADD, 16'h0008, 24'h000008);
		send_cmd(bil_pkg::CMD_LIST, 16'h0000, 24'h000000);
		wait_drained();
	endtask

	// fill to the oversized capacity at top prices, list the largest total, trim the middle
	task automatic test_fill_to_capacity();
		int k;
		write_capacity(6'd63);
		while (held_count < eff_capacity())
			send_cmd(bil_pkg::CMD_ADD, 16'($urandom()), 24'hFFFFFF);
		send_cmd(bil_pkg::CMD_ADD, 16'h0001, 24'h000001);
		send_cmd(bil_pkg::CMD_ADD, 16'hFFFF, 24'hFFFFFF);
		send_cmd(bil_pkg::CMD_LIST, 16'h0000, 24'h000000);
		for (k = 0; k < 3; k++)
			send_cmd(bil_pkg::CMD_DELETE,
				held_entries[$urandom_range(1, held_count - 2)].number, 24'($urandom()));
		send_cmd(bil_pkg::CMD_DELETE, held_entries[held_count - 1].number, 24'h000000);
		send_cmd(bil_pkg::CMD_LIST, 16'h0000, 24'h000000);
		wait_drained();
	endtask

	function automatic logic [bil_pkg::NUM_W-1:0] pick_number();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3, 4: return bil_pkg::NUM_W'($urandom_range(0, 15));
			default: return bil_pkg::NUM_W'($urandom());
		endcase
	endfunction

	function automatic logic [bil_pkg::PRICE_W-1:0] pick_price();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return bil_pkg::PRICE_W'($urandom());
		endcase
	endfunction

	// random mix weighted toward adds and deletes of stored numbers
	task automatic test_random_phase(input int n_words, input logic [bil_pkg::CAP_W-1:0] cap);
		int k;
		int pick;
		bil_pkg::bil_req_t w;
		write_capacity(cap);
		for (k = 0; k < n_words; k++) begin
			pick = $urandom_range(0, 99);
			w.item_number = pick_number();
			w.item_price = pick_price();
			if (pick < 45) begin
				w.command = bil_pkg::CMD_ADD;
			end else if (pick < 72) begin
				w.command = bil_pkg::CMD_DELETE;
				if (held_count > 0 && $urandom_range(0, 3) != 0)
					w.item_number = held_entries[$urandom_range(0, held_count - 1)].number;
			end else if (pick < 95) begin
				w.command = bil_pkg::CMD_LIST;
			end else begin
				w.command = CMD_UNUSED;
			end
			send_word(w);
			// pause now and then until every owed word is back
			if ($urandom_range(0, 59) == 0)
				wait_drained();
		end
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		held_count = 0;
		cap_setting = bil_pkg::CAP_RESET;
		burst_left = 0;
		words_sent = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_list();
		test_edge_values();
		test_capacity_limits();
		test_fill_to_capacity();
		test_random_phase(61, 6'd1);
		test_random_phase(61, 6'd0);
		test_random_phase(61, 6'd33);
		test_random_phase(61, 6'd32);
		test_random_phase(61, 6'($urandom_range(2, 31)));
		test_random_phase(61, 6'd5);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("sent %0d request words, checked %0d response words", words_sent,
			words_checked);
		$display("capacities 0, 1, 2, 5, 32, 33, 63 and one random; empty, full and lowered lists");
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
